FILE: hw/rtl/fhd_pkg.sv
// Shared types and constants of the frame header deframer.
// Used by the configuration, parser, queue and top-level modules.
`default_nettype none

package fhd_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int POS_W = 17;
    localparam int LEN_W = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_ADDR_W = 4;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_HDR = POS_W'(HEADER_BYTES);

    localparam logic [POS_W-1:0] OFS_MAGIC0 = POS_W'(0);
    localparam logic [POS_W-1:0] OFS_MAGIC1 = POS_W'(1);
    localparam logic [POS_W-1:0] OFS_VERSION = POS_W'(2);
    localparam logic [POS_W-1:0] OFS_TYPE = POS_W'(3);
    localparam logic [POS_W-1:0] OFS_FLAGS = POS_W'(4);
    localparam logic [POS_W-1:0] OFS_HDRLEN = POS_W'(5);
    localparam logic [POS_W-1:0] OFS_SEQ_LO = POS_W'(6);
    localparam logic [POS_W-1:0] OFS_SEQ_HI = POS_W'(7);
    localparam logic [POS_W-1:0] OFS_XID_LO = POS_W'(8);
    localparam logic [POS_W-1:0] OFS_XID_HI = POS_W'(9);
    localparam logic [POS_W-1:0] OFS_LEN_LO = POS_W'(10);
    localparam logic [POS_W-1:0] OFS_LEN_HI = POS_W'(11);

    localparam logic [CFG_ADDR_W-1:0] ADDR_MAGIC_FIRST = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] ADDR_MAGIC_SECOND = CFG_ADDR_W'(4);
    localparam logic [CFG_ADDR_W-1:0] ADDR_PROTOCOL_VERSION = CFG_ADDR_W'(8);

    localparam logic [7:0] RESET_MAGIC_FIRST = 8'd0;
    localparam logic [7:0] RESET_MAGIC_SECOND = 8'd0;
    localparam logic [7:0] RESET_PROTOCOL_VERSION = 8'd1;

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_BAD_FRAME = 2'd1,
        STATUS_BAD_VERSION = 2'd2
    } fhd_status_t;

    typedef struct packed {
        logic [7:0] magic_first;
        logic [7:0] magic_second;
        logic [7:0] protocol_version;
    } fhd_cfg_t;

    typedef struct packed {
        logic              is_report;
        logic [7:0]        payload_byte;
        logic              payload_end;
        fhd_status_t       status;
        logic [7:0]        msg_type;
        logic [7:0]        msg_flags;
        logic [LEN_W-1:0]  sequence_res;
        logic [LEN_W-1:0]  transaction;
        logic [LEN_W-1:0]  payload_length;
    } fhd_result_t;

    typedef struct packed {
        logic        first_valid;
        logic        second_valid;
        fhd_result_t first;
        fhd_result_t second;
    } fhd_push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/frame_header_deframer.sv
// Frame header deframer top level: one received byte per input word.
// Result words are queued as their byte is accepted and offered in order.
// Throughput: one byte per cycle while the queue has room; a byte can yield
// both a payload word and a report, so the input stalls when the result queue
// has fewer than two free entries. Reset (aresetn low, synchronous) clears
// the parse state and the queue and loads the register defaults.
`default_nettype none

module frame_header_deframer
    import fhd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // rx_byte
    input  wire logic                  s_tlast,   // buffer_last
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // payload_byte [7:0], status [9:8], msg_type [17:10], msg_flags [25:18],
    // sequence_res [41:26], transaction [57:42], payload_length [73:58], zeros above
    output logic      [79:0]           m_tdata,
    output logic                       m_tlast,   // payload_end
    output logic                       m_tuser    // is_report
);

    fhd_cfg_t    cfg;
    fhd_push_t   push;
    fhd_result_t out_word;
    logic        room;
    logic        in_accept;

    assign s_tready  = room;
    assign in_accept = s_tvalid && s_tready;

    fhd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fhd_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .rx_byte     (s_tdata),
        .buffer_last (s_tlast),
        .cfg         (cfg),
        .push        (push)
    );

    fhd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {6'd0, out_word.payload_length, out_word.transaction,
                      out_word.sequence_res, out_word.msg_flags, out_word.msg_type,
                      out_word.status, out_word.payload_byte};
    assign m_tlast = out_word.payload_end;
    assign m_tuser = out_word.is_report;

endmodule

`default_nettype wire

FILE: hw/rtl/fhd_cfg.sv
// APB-style register file holding the magic and version match values.
// Depends on fhd_pkg.
`default_nettype none

module fhd_cfg
    import fhd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output fhd_cfg_t                   cfg
);

    fhd_cfg_t cfg_reg;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_first      <= RESET_MAGIC_FIRST;
            cfg_reg.magic_second     <= RESET_MAGIC_SECOND;
            cfg_reg.protocol_version <= RESET_PROTOCOL_VERSION;
        end else if (wr_en) begin
            unique case (paddr)
                ADDR_MAGIC_FIRST:      cfg_reg.magic_first <= pwdata[7:0];
                ADDR_MAGIC_SECOND:     cfg_reg.magic_second <= pwdata[7:0];
                ADDR_PROTOCOL_VERSION: cfg_reg.protocol_version <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_MAGIC_FIRST:      prdata = {24'd0, cfg_reg.magic_first};
            ADDR_MAGIC_SECOND:     prdata = {24'd0, cfg_reg.magic_second};
            ADDR_PROTOCOL_VERSION: prdata = {24'd0, cfg_reg.protocol_version};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fhd_parse.sv
// Header parser: byte position counter, header field capture and checks,
// a payload word for each payload byte and a report at each buffer end.
// Depends on fhd_pkg.
`default_nettype none

module fhd_parse
    import fhd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_accept,
    input  wire logic [7:0] rx_byte,
    input  wire logic       buffer_last,
    input  wire fhd_cfg_t   cfg,
    output fhd_push_t       push
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             magic_reg, magic_next;
    logic             version_reg, version_next;
    logic             hdrlen_reg, hdrlen_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       flags_reg, flags_next;
    logic [LEN_W-1:0] seq_reg, seq_next;
    logic [LEN_W-1:0] xid_reg, xid_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic [POS_W-1:0] frame_end;
    logic             header_good;
    logic             is_payload;
    fhd_status_t      status;
    fhd_result_t      payload_word;
    fhd_result_t      report_word;

    always_comb begin
        magic_next   = magic_reg;
        version_next = version_reg;
        hdrlen_next  = hdrlen_reg;
        type_next    = type_reg;
        flags_next   = flags_reg;
        seq_next     = seq_reg;
        xid_next     = xid_reg;
        len_next     = len_reg;
        unique case (pos_reg)
            OFS_MAGIC0:  magic_next = (rx_byte == cfg.magic_first);
            OFS_MAGIC1:  magic_next = magic_reg && (rx_byte == cfg.magic_second);
            OFS_VERSION: version_next = (rx_byte == cfg.protocol_version);
            OFS_TYPE:    type_next = rx_byte;
            OFS_FLAGS:   flags_next = rx_byte;
            OFS_HDRLEN:  hdrlen_next = (rx_byte == 8'(HEADER_BYTES));
            OFS_SEQ_LO:  seq_next = {8'd0, rx_byte};
            OFS_SEQ_HI:  seq_next = {rx_byte, seq_reg[7:0]};
            OFS_XID_LO:  xid_next = {8'd0, rx_byte};
            OFS_XID_HI:  xid_next = {rx_byte, xid_reg[7:0]};
            OFS_LEN_LO:  len_next = {8'd0, rx_byte};
            OFS_LEN_HI:  len_next = {rx_byte, len_reg[7:0]};
            default: ;
        endcase

        pos_next    = (pos_reg != POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
        frame_end   = POS_HDR + POS_W'(len_next);
        header_good = magic_next && version_next && hdrlen_next;
        is_payload  = (pos_reg >= POS_HDR) && header_good && (pos_reg < frame_end);

        if (pos_next < POS_HDR || !magic_next) begin
            status = STATUS_BAD_FRAME;
        end else if (!version_next) begin
            status = STATUS_BAD_VERSION;
        end else if (!hdrlen_next || frame_end > pos_next) begin
            status = STATUS_BAD_FRAME;
        end else begin
            status = STATUS_OK;
        end

        payload_word              = '0;
        payload_word.payload_byte = rx_byte;
        payload_word.payload_end  = (pos_next == frame_end);
        payload_word.status       = STATUS_OK;

        report_word           = '0;
        report_word.is_report = 1'b1;
        report_word.status    = status;
        if (status == STATUS_OK) begin
            report_word.msg_type       = type_next;
            report_word.msg_flags      = flags_next;
            report_word.sequence_res   = seq_next;
            report_word.transaction    = xid_next;
            report_word.payload_length = len_next;
        end

        push.first_valid  = in_accept && (is_payload || buffer_last);
        push.second_valid = in_accept && is_payload && buffer_last;
        push.first        = is_payload ? payload_word : report_word;
        push.second       = report_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            magic_reg   <= 1'b1;
            version_reg <= 1'b1;
            hdrlen_reg  <= 1'b1;
            type_reg    <= '0;
            flags_reg   <= '0;
            seq_reg     <= '0;
            xid_reg     <= '0;
            len_reg     <= '0;
        end else if (in_accept) begin
            if (buffer_last) begin
                pos_reg     <= '0;
                magic_reg   <= 1'b1;
                version_reg <= 1'b1;
                hdrlen_reg  <= 1'b1;
                type_reg    <= '0;
                flags_reg   <= '0;
                seq_reg     <= '0;
                xid_reg     <= '0;
                len_reg     <= '0;
            end else begin
                pos_reg     <= pos_next;
                magic_reg   <= magic_next;
                version_reg <= version_next;
                hdrlen_reg  <= hdrlen_next;
                type_reg    <= type_next;
                flags_reg   <= flags_next;
                seq_reg     <= seq_next;
                xid_reg     <= xid_next;
                len_reg     <= len_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fhd_queue.sv
// Small result queue that takes up to two words a cycle and hands out one while out_ready is high.
// Depends on fhd_pkg.
`default_nettype none

module fhd_queue
    import fhd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire fhd_push_t push,
    output logic           room,
    output logic           out_valid,
    input  wire logic      out_ready,
    output fhd_result_t    out_word
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fhd_result_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_second;
    logic             pop;

    assign room          = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid     = (count_reg != '0);
    assign out_word      = mem_reg[rd_ptr_reg];
    assign pop           = out_valid && out_ready;
    assign wr_ptr_second = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        count_next = count_reg + CNT_W'(push.first_valid) + CNT_W'(push.second_valid)
                     - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.first_valid) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid) begin
            mem_reg[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.first_valid) + PTR_W'(push.second_valid);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire
